@@ rtl/alarm_keypad_code_lock_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the alarm keypad code lock
// Clocked property checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ALARM_KEYPAD_CODE_LOCK_TOP_ASSERT_SVH
`define ALARM_KEYPAD_CODE_LOCK_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define AKCL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("alarm keypad code lock assertion failed");
`define AKCL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("alarm keypad code lock assertion failed");
`else
`define AKCL_ASSERT(lbl, clk, rst_n, prop)
`define AKCL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/akcl_pkg.sv @@
// ----------------------------------------------------------------------------
// Alarm keypad code lock package
// Field widths, key codes, mode and notice codes, register indexes.
// ----------------------------------------------------------------------------
package akcl_pkg;

  localparam int CODE_LENGTH_DEFAULT = 4;

  localparam int KEY_W    = 8;
  localparam int MODE_W   = 3;
  localparam int NOTICE_W = 2;
  localparam int COUNT_W  = 4;
  localparam int POLL_W   = 16;
  localparam int SECRET_W = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [SECRET_W-1:0] SECRET_RESET = 64'h0000_0000_3433_3231;
  localparam logic [POLL_W-1:0]   LIMIT_RESET  = 16'd300;
  localparam logic [POLL_W-1:0]   POLL_MAX     = 16'hFFFF;

  localparam logic [KEY_W-1:0] KEY_NONE = 8'd122;
  localparam logic [KEY_W-1:0] KEY_HASH = 8'd35;
  localparam logic [KEY_W-1:0] KEY_STAR = 8'd42;
  localparam logic [KEY_W-1:0] KEY_ZERO = 8'd48;
  localparam logic [KEY_W-1:0] KEY_NINE = 8'd57;

  localparam logic [CFG_IDX_W-1:0] REG_SECRET_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT  = 2'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ARMED     = 3'd0,
    MODE_ENTRY     = 3'd1,
    MODE_DISARMED  = 3'd2,
    MODE_RESETTING = 3'd3,
    MODE_TIMEOUT   = 3'd4
  } mode_t;

  typedef enum logic [NOTICE_W-1:0] {
    NOTICE_NONE       = 2'd0,
    NOTICE_WRONG_CODE = 2'd1,
    NOTICE_RESET_REQ  = 2'd2,
    NOTICE_RESET_DONE = 2'd3
  } notice_t;

endpackage

@@ rtl/alarm_keypad_code_lock_top.sv @@
// ----------------------------------------------------------------------------
// Alarm keypad code lock, top level
// Keypad code entry with motion start, backspace, timeout and reset button.
// ----------------------------------------------------------------------------
// Each input beat is one poll tick. The lock takes one beat per clock cycle
// and delivers its status beat from an output register in the cycle after
// acceptance; a new beat is accepted whenever that register is empty or is
// being taken in the same cycle. The whole tick (mode update, digit store
// and the parallel compare of all code digits) is one registered update.
// There is no clearing pass after reset.
`include "alarm_keypad_code_lock_top_assert.svh"

module alarm_keypad_code_lock_top #(
  parameter int CODE_LENGTH = akcl_pkg::CODE_LENGTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [akcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [akcl_pkg::SECRET_W-1:0]   cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [akcl_pkg::KEY_W-1:0]      in_key_code,
  input  logic                            in_motion,
  input  logic                            in_reset_button,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [akcl_pkg::MODE_W-1:0]     out_mode_code,
  output logic [akcl_pkg::NOTICE_W-1:0]   out_notice,
  output logic                            out_buzzer_on,
  output logic [akcl_pkg::COUNT_W-1:0]    out_digits_held
);
  import akcl_pkg::*;

  localparam logic [COUNT_W-1:0] CODE_LEN = COUNT_W'(CODE_LENGTH);

  logic [SECRET_W-1:0] secret_code_r;
  logic [POLL_W-1:0]   poll_limit_r;

  mode_t               mode_r, mode_nxt;
  logic [KEY_W-1:0]    digits_r [CODE_LENGTH];
  logic [KEY_W-1:0]    digits_nxt [CODE_LENGTH];
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [POLL_W-1:0]   poll_r, poll_nxt;
  logic                await_r, await_nxt;
  notice_t             notice_nxt;

  logic                out_valid_r;
  logic [MODE_W-1:0]   out_mode_r;
  logic [NOTICE_W-1:0] out_notice_r;
  logic                out_buzzer_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic                in_fire;
  logic                code_match;
  logic                is_digit;
  logic [POLL_W-1:0]   poll_inc;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      secret_code_r <= SECRET_RESET;
      poll_limit_r  <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_SECRET_CODE) begin
        secret_code_r <= cfg_wdata;
      end else if (cfg_index == REG_POLL_LIMIT) begin
        poll_limit_r <= cfg_wdata[POLL_W-1:0];
      end
    end
  end

  always_comb begin
    code_match = (count_r == CODE_LEN);
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (digits_r[i] != secret_code_r[8*i +: 8]) begin
        code_match = 1'b0;
      end
    end
  end

  assign is_digit = (in_key_code >= KEY_ZERO) && (in_key_code <= KEY_NINE);
  assign poll_inc = (poll_r < POLL_MAX) ? poll_r + 16'd1 : poll_r;

  always_comb begin
    mode_nxt   = mode_r;
    digits_nxt = digits_r;
    count_nxt  = count_r;
    poll_nxt   = poll_r;
    await_nxt  = await_r;
    notice_nxt = NOTICE_NONE;
    unique case (mode_r)
      MODE_ARMED: begin
        if (in_motion) begin
          for (int i = 0; i < CODE_LENGTH; i++) digits_nxt[i] = '0;
          count_nxt = '0;
          poll_nxt  = '0;
          await_nxt = 1'b0;
          mode_nxt  = MODE_ENTRY;
        end
      end
      MODE_ENTRY: begin
        if (await_r) begin
          if (in_key_code == KEY_NONE) begin
            await_nxt = 1'b0;
            poll_nxt  = poll_inc;
          end
        end else if (in_key_code == KEY_HASH) begin
          if (code_match) begin
            mode_nxt = MODE_DISARMED;
          end else begin
            notice_nxt = NOTICE_WRONG_CODE;
            for (int i = 0; i < CODE_LENGTH; i++) digits_nxt[i] = '0;
            count_nxt = '0;
            poll_nxt  = '0;
            await_nxt = 1'b0;
          end
        end else if (poll_r >= poll_limit_r) begin
          mode_nxt = MODE_TIMEOUT;
        end else begin
          if (is_digit && (count_r < CODE_LEN)) begin
            for (int i = 0; i < CODE_LENGTH; i++) begin
              if (count_r == COUNT_W'(i)) digits_nxt[i] = in_key_code;
            end
            count_nxt = count_r + 4'd1;
            await_nxt = 1'b1;
          end else if ((in_key_code == KEY_STAR) && (count_r != '0)) begin
            for (int i = 0; i < CODE_LENGTH; i++) begin
              if (count_r == COUNT_W'(i + 1)) digits_nxt[i] = '0;
            end
            count_nxt = count_r - 4'd1;
            await_nxt = 1'b1;
          end
          poll_nxt = poll_inc;
        end
      end
      MODE_DISARMED, MODE_TIMEOUT: begin
        if (in_reset_button) begin
          notice_nxt = NOTICE_RESET_REQ;
          mode_nxt   = MODE_RESETTING;
        end
      end
      MODE_RESETTING: begin
        for (int i = 0; i < CODE_LENGTH; i++) digits_nxt[i] = '0;
        count_nxt  = '0;
        poll_nxt   = '0;
        await_nxt  = 1'b0;
        notice_nxt = NOTICE_RESET_DONE;
        mode_nxt   = MODE_ARMED;
      end
      default: begin
        mode_nxt = MODE_ARMED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ARMED;
      count_r <= '0;
      poll_r  <= '0;
      await_r <= 1'b0;
      for (int i = 0; i < CODE_LENGTH; i++) digits_r[i] <= '0;
    end else if (in_fire) begin
      mode_r   <= mode_nxt;
      count_r  <= count_nxt;
      poll_r   <= poll_nxt;
      await_r  <= await_nxt;
      digits_r <= digits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_mode_r   <= mode_nxt;
      out_notice_r <= notice_nxt;
      out_buzzer_r <= (mode_nxt == MODE_TIMEOUT);
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mode_code   = out_mode_r;
  assign out_notice      = out_notice_r;
  assign out_buzzer_on   = out_buzzer_r;
  assign out_digits_held = out_count_r;

  `AKCL_ASSERT(a_count_in_range, clk, rst_n, count_r <= CODE_LEN)
  `AKCL_ASSERT(a_stall_blocks_input, clk, rst_n,
               (out_valid_r && !out_ready) |-> !in_ready)
  `AKCL_ASSERT(a_resetting_one_tick, clk, rst_n,
               (in_fire && mode_r == MODE_RESETTING) |=> (mode_r == MODE_ARMED))
  `AKCL_ASSERT(a_buzzer_tracks_mode, clk, rst_n,
               out_valid_r |-> (out_buzzer_r == (out_mode_r == MODE_TIMEOUT)))
  `AKCL_ASSERT(a_reset_done_armed, clk, rst_n,
               (out_valid_r && out_notice_r == NOTICE_RESET_DONE)
                 |-> (out_mode_r == MODE_ARMED && out_count_r == '0))

endmodule
